// File: design/mwpi_pkg.sv
// Shared widths, constants and saturation helpers for the mecanum PI speed controller.
package mwpi_pkg;

    localparam int WHEEL_COUNT      = 4;
    localparam int HEADING_RATIO_Q8 = 256;
    localparam int INTEGRATOR_LIMIT = 12000;
    localparam int OUTPUT_LIMIT     = 30000;

    // error / setpoint width, signed gain operand width, product width
    localparam int E_W   = 26;
    localparam int G_W   = 17;
    localparam int P_W   = E_W + G_W;
    localparam int ACC_W = P_W + 1;
    localparam int INT_W = 24;
    localparam int CFG_IDX_W = 3;

    localparam logic signed [G_W-1:0]   HEAD_RATIO = G_W'(HEADING_RATIO_Q8);
    localparam logic signed [ACC_W-1:0] ILIM = ACC_W'(INTEGRATOR_LIMIT * 256);
    localparam logic signed [ACC_W-1:0] OLIM = ACC_W'(OUTPUT_LIMIT * 256);

    typedef logic signed [E_W-1:0]   t_err;
    typedef logic signed [G_W-1:0]   t_gain;
    typedef logic signed [P_W-1:0]   t_prod;
    typedef logic signed [ACC_W-1:0] t_acc;

    function automatic t_acc sat(input t_acc x, input t_acc lim);
        if (x > lim) begin
            return lim;
        end else if (x < -lim) begin
            return -lim;
        end
        return x;
    endfunction

endpackage

// File: design/mwpi_mul.sv
// Shared signed multiplier with registered product.
module mwpi_mul (
    input  logic                 i_clk,
    input  logic                 i_en,
    input  mwpi_pkg::t_err       i_a,
    input  mwpi_pkg::t_gain      i_b,
    output mwpi_pkg::t_prod      o_p
);

    mwpi_pkg::t_prod r_p;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_p <= mwpi_pkg::P_W'(i_a * i_b);
        end
    end

    assign o_p = r_p;

endmodule

// File: design/mecanum_wheel_pi_speed_control_core.sv
// Top level: mecanum wheel mixer and four-wheel PI speed loop on one shared multiplier.
//
// One item is one control tick: strafe, drive and turn commands, four measured
// wheel speeds and the two side-hold flags. The block scales the turn command
// by the heading ratio, mixes the four wheel setpoints and runs the PI update
// of each wheel in turn (front right, back right, front left, back left) on a
// single 26x17 signed multiplier. After acceptance the block forms the
// heading product and rounds it, then per wheel the error, the integral
// product, the integrator update, the proportional product and the sum with
// saturation, then loads the result register and goes back to idle, where
// the next item is taken; the steps run one after another and share the
// multiplier. While an item is at work o_s_tready is low. The result sits in
// an output register, so the next item is accepted while a result still
// waits; a new result is held back only if the previous one has not been
// taken. Integrators are 24-bit Q.8 and clamp to +/-12000; currents clamp to
// +/-30000 and round toward zero. A held side still updates its integrators,
// only its outputs read zero. Gains must be written through the config port
// only while the block is idle; the block itself does not enforce this.
module mecanum_wheel_pi_speed_control_core (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    // config write port
    input  logic                               i_cfg_we,
    input  logic [mwpi_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [15:0]                        i_cfg_data,
    // input stream
    input  logic                               i_s_tvalid,
    output logic                               o_s_tready,
    // strafe, drive, turn, speed fr, speed br, speed fl, speed bl (16 b each)
    input  logic [111:0]                       i_s_tdata,
    // hold_right_side, hold_left_side
    input  logic [1:0]                         i_s_tuser,
    // result stream
    output logic                               o_m_tvalid,
    input  logic                               i_m_tready,
    // current fr, current br, current fl, current bl (16 b each)
    output logic [63:0]                        o_m_tdata
);

    typedef enum logic [3:0] {
        S_IDLE, S_HEAD, S_SETP, S_ERR, S_MULI, S_INT, S_MULP, S_SUM, S_DONE
    } t_state;

    t_state r_state;
    logic [1:0] r_wheel;

    // gains
    logic [15:0] r_kp [mwpi_pkg::WHEEL_COUNT];
    logic [15:0] r_ki [mwpi_pkg::WHEEL_COUNT];
    // integrators, Q.8
    logic signed [mwpi_pkg::INT_W-1:0] r_integ [mwpi_pkg::WHEEL_COUNT];

    // latched item
    logic signed [15:0] r_strafe, r_drive, r_turn;
    logic signed [15:0] r_speed [mwpi_pkg::WHEEL_COUNT];
    logic               r_hold_r, r_hold_l;

    mwpi_pkg::t_err                    r_h;
    mwpi_pkg::t_err                    r_err;
    logic signed [mwpi_pkg::INT_W-1:0] r_acc;
    logic [15:0]                       r_cur [mwpi_pkg::WHEEL_COUNT];
    logic                              r_out_valid;
    logic [63:0]                       r_odata;

    logic s_acc;
    logic w_load;
    assign o_s_tready = (r_state == S_IDLE);
    assign s_acc      = i_s_tvalid && o_s_tready;
    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_odata;
    // result register loads once the previous result is gone or leaving
    assign w_load     = (r_state == S_DONE) && (!r_out_valid || i_m_tready);

    // shared multiplier operand select
    logic             mul_en;
    mwpi_pkg::t_err   mul_a;
    mwpi_pkg::t_gain  mul_b;
    mwpi_pkg::t_prod  mul_p;

    always_comb begin
        mul_en = 1'b0;
        mul_a  = r_err;
        mul_b  = signed'({1'b0, r_ki[r_wheel]});
        unique case (r_state)
            S_HEAD: begin
                mul_en = 1'b1;
                mul_a  = mwpi_pkg::E_W'(r_turn);
                mul_b  = mwpi_pkg::HEAD_RATIO;
            end
            S_MULI: begin
                mul_en = 1'b1;
            end
            S_MULP: begin
                mul_en = 1'b1;
                mul_b  = signed'({1'b0, r_kp[r_wheel]});
            end
            default: begin
                mul_en = 1'b0;
            end
        endcase
    end

    mwpi_mul u_mul (
        .i_clk (i_clk),
        .i_en  (mul_en),
        .i_a   (mul_a),
        .i_b   (mul_b),
        .o_p   (mul_p)
    );

    // heading term: floor((t*ratio + 128) / 256)
    mwpi_pkg::t_prod w_hround;
    mwpi_pkg::t_prod w_hshift;
    assign w_hround = mul_p + mwpi_pkg::P_W'(128);
    assign w_hshift = w_hround >>> 8;

    // setpoint and error of the current wheel
    mwpi_pkg::t_err w_s, w_d, w_sp, w_e;
    assign w_s  = mwpi_pkg::E_W'(r_strafe);
    assign w_d  = mwpi_pkg::E_W'(r_drive);
    always_comb begin
        unique case (r_wheel)
            2'd0:    w_sp = -w_s - w_d - r_h;
            2'd1:    w_sp = -w_s + w_d - r_h;
            2'd2:    w_sp =  w_s + w_d - r_h;
            default: w_sp =  w_s - w_d - r_h;
        endcase
    end
    assign w_e = w_sp - mwpi_pkg::E_W'(r_speed[r_wheel]);

    // integrator update
    mwpi_pkg::t_acc w_int_raw, w_int_sat;
    assign w_int_raw = mwpi_pkg::ACC_W'(r_integ[r_wheel]) + mwpi_pkg::ACC_W'(mul_p);
    assign w_int_sat = mwpi_pkg::sat(w_int_raw, mwpi_pkg::ILIM);

    // output sum, saturate, truncate toward zero
    mwpi_pkg::t_acc w_sum_raw, w_sum_sat, w_sum_bias, w_sum_shift;
    logic           w_held;
    assign w_sum_raw   = mwpi_pkg::ACC_W'(mul_p) + mwpi_pkg::ACC_W'(r_acc);
    assign w_sum_sat   = mwpi_pkg::sat(w_sum_raw, mwpi_pkg::OLIM);
    assign w_sum_bias  = w_sum_sat[mwpi_pkg::ACC_W-1] ?
                         (w_sum_sat + mwpi_pkg::ACC_W'(255)) : w_sum_sat;
    assign w_sum_shift = w_sum_bias >>> 8;
    assign w_held      = r_wheel[1] ? r_hold_l : r_hold_r;

    // config writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < mwpi_pkg::WHEEL_COUNT; i++) begin
                r_kp[i] <= '0;
                r_ki[i] <= '0;
            end
        end else if (i_cfg_we) begin
            if (i_cfg_idx[2]) begin
                r_ki[i_cfg_idx[1:0]] <= i_cfg_data;
            end else begin
                r_kp[i_cfg_idx[1:0]] <= i_cfg_data;
            end
        end
    end

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_wheel     <= '0;
            r_out_valid <= 1'b0;
            for (int i = 0; i < mwpi_pkg::WHEEL_COUNT; i++) begin
                r_integ[i] <= '0;
            end
        end else begin
            if (w_load) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && i_m_tready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (s_acc) begin
                        r_strafe   <= i_s_tdata[15:0];
                        r_drive    <= i_s_tdata[31:16];
                        r_turn     <= i_s_tdata[47:32];
                        r_speed[0] <= i_s_tdata[63:48];
                        r_speed[1] <= i_s_tdata[79:64];
                        r_speed[2] <= i_s_tdata[95:80];
                        r_speed[3] <= i_s_tdata[111:96];
                        r_hold_r   <= i_s_tuser[0];
                        r_hold_l   <= i_s_tuser[1];
                        r_wheel    <= '0;
                        r_state    <= S_HEAD;
                    end
                end
                S_HEAD: begin
                    r_state <= S_SETP;
                end
                S_SETP: begin
                    r_h     <= w_hshift[mwpi_pkg::E_W-1:0];
                    r_state <= S_ERR;
                end
                S_ERR: begin
                    r_err   <= w_e;
                    r_state <= S_MULI;
                end
                S_MULI: begin
                    r_state <= S_INT;
                end
                S_INT: begin
                    r_integ[r_wheel] <= w_int_sat[mwpi_pkg::INT_W-1:0];
                    r_acc            <= w_int_sat[mwpi_pkg::INT_W-1:0];
                    r_state          <= S_MULP;
                end
                S_MULP: begin
                    r_state <= S_SUM;
                end
                S_SUM: begin
                    r_cur[r_wheel] <= w_held ? 16'd0 : w_sum_shift[15:0];
                    if (r_wheel == 2'd3) begin
                        r_state <= S_DONE;
                    end else begin
                        r_wheel <= r_wheel + 2'd1;
                        r_state <= S_ERR;
                    end
                end
                S_DONE: begin
                    // hold the result back until the previous one is taken
                    if (w_load) begin
                        r_odata <= {r_cur[3], r_cur[2], r_cur[1], r_cur[0]};
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // accepted item starts the heading product next cycle
    a_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_acc |=> (r_state == S_HEAD))
        else $error("sequencer did not start after accept");

    // the stored integrator never leaves its clamp range
    a_int_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_integ[r_wheel] <= mwpi_pkg::INT_W'(mwpi_pkg::INTEGRATOR_LIMIT * 256)) &&
        (r_integ[r_wheel] >= -mwpi_pkg::INT_W'(mwpi_pkg::INTEGRATOR_LIMIT * 256)))
        else $error("integrator out of range");

    // a finished wheel current is inside the output clamp
    a_cur_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SUM) |=>
        ($signed(r_cur[$past(r_wheel)]) <= 16'sd30000) &&
        ($signed(r_cur[$past(r_wheel)]) >= -16'sd30000))
        else $error("wheel current out of range");

    // an unaccepted result is never overwritten
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !i_m_tready) |=> $stable(r_odata))
        else $error("pending result overwritten");

endmodule
